@@ src/hsvrgb_pkg.sv @@
// Package for the HSV/HSL to RGB converter: word types, widths and hue sector codes.
// Has no dependencies. The converter top level uses it.
package hsvrgb_pkg;

    // Component width: all-ones stands for 1.0
    localparam int unsigned CB = 16;
    localparam logic [CB-1:0] FULL_SCALE = {CB{1'b1}};

    // Hue sectors of 60 degrees each
    localparam logic [2:0] SECT_RY = 3'd0;  // red to yellow
    localparam logic [2:0] SECT_YG = 3'd1;  // yellow to green
    localparam logic [2:0] SECT_GC = 3'd2;  // green to cyan
    localparam logic [2:0] SECT_CB = 3'd3;  // cyan to blue
    localparam logic [2:0] SECT_BM = 3'd4;  // blue to magenta
    localparam logic [2:0] SECT_MR = 3'd5;  // magenta to red

    // Color model select
    localparam logic MODEL_HSV = 1'b0;
    localparam logic MODEL_HSL = 1'b1;

    typedef struct packed {
        logic          op;
        logic [CB-1:0] hue;
        logic [CB-1:0] saturation;
        logic [CB-1:0] level;
    } t_hsl_in;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_rgb_out;

endpackage

@@ src/hsv_hsl_to_rgb_converter.sv @@
// Throughput: one word per cycle; the five-stage pipeline advances as a whole
// and holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all stage valid bits; data registers
// are not reset. A 16x16 chroma and a 16x17 ramp multiplier set the stage cut.
// Depends on hsvrgb_pkg for word types, widths and sector codes.
module hsv_hsl_to_rgb_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvrgb_pkg::t_hsl_in   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvrgb_pkg::t_rgb_out  o_data
);

    localparam int unsigned N = hsvrgb_pkg::CB;

    // Pipeline enable: advance unless the output word is stalled
    logic w_en;
    logic [4:0] r_vld;

    assign w_en    = !r_vld[4] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[4];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Stage 1: sector split, multiplier operand, ramp operand
    logic [N+2:0] n_turn;
    logic [N-1:0] n_lo;
    logic [N-1:0] n_mul_a;
    logic [N:0]   n_ramp;
    logic [N-1:0] n_frac;
    logic [2:0]   n_sector;

    logic         r1_op;
    logic [N-1:0] r1_lev;
    logic [N-1:0] r1_a;
    logic [N-1:0] r1_sat;
    logic [2:0]   r1_sector;
    logic [N:0]   r1_ramp;

    always_comb begin
        n_turn   = {i_data.hue, 2'b00} + {1'b0, i_data.hue, 1'b0};
        n_sector = n_turn[N+2:N];
        n_frac   = n_turn[N-1:0];
        if (n_sector[0]) begin
            n_ramp = {1'b1, {N{1'b0}}} - {1'b0, n_frac};
        end else begin
            n_ramp = {1'b0, n_frac};
        end
        if (i_data.level < (hsvrgb_pkg::FULL_SCALE - i_data.level)) begin
            n_lo = i_data.level;
        end else begin
            n_lo = hsvrgb_pkg::FULL_SCALE - i_data.level;
        end
        if (i_data.op == hsvrgb_pkg::MODEL_HSL) begin
            n_mul_a = {n_lo[N-2:0], 1'b0};
        end else begin
            n_mul_a = i_data.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op     <= i_data.op;
            r1_lev    <= i_data.level;
            r1_a      <= n_mul_a;
            r1_sat    <= i_data.saturation;
            r1_sector <= n_sector;
            r1_ramp   <= n_ramp;
        end
    end

    // Stage 2: chroma product
    logic           r2_op;
    logic [N-1:0]   r2_lev;
    logic [2*N-1:0] r2_prod;
    logic [2:0]     r2_sector;
    logic [N:0]     r2_ramp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op     <= r1_op;
            r2_lev    <= r1_lev;
            r2_prod   <= r1_a * r1_sat;
            r2_sector <= r1_sector;
            r2_ramp   <= r1_ramp;
        end
    end

    // Stage 3: divide by full scale (shift, add back, one correction), offset
    logic [N-1:0] n_quot;
    logic [N:0]   n_rem;
    logic [N-1:0] n_chroma;
    logic [N-1:0] n_offset;

    logic [N-1:0] r3_chroma;
    logic [N-1:0] r3_offset;
    logic [N-1:0] r3_lev;
    logic [2:0]   r3_sector;
    logic [N:0]   r3_ramp;

    always_comb begin
        n_quot = r2_prod[2*N-1:N];
        n_rem  = {1'b0, r2_prod[N-1:0]} + {1'b0, n_quot};
        if (n_rem >= {1'b0, hsvrgb_pkg::FULL_SCALE}) begin
            n_chroma = n_quot + 1'b1;
        end else begin
            n_chroma = n_quot;
        end
        if (r2_op == hsvrgb_pkg::MODEL_HSL) begin
            n_offset = r2_lev - {1'b0, n_chroma[N-1:1]};
        end else begin
            n_offset = r2_lev - n_chroma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_chroma <= n_chroma;
            r3_offset <= n_offset;
            r3_lev    <= r2_lev;
            r3_sector <= r2_sector;
            r3_ramp   <= r2_ramp;
        end
    end

    // Stage 4: secondary component from the in-sector ramp
    logic [2*N:0] n_xprod;

    logic [N-1:0] r4_chroma;
    logic [N-1:0] r4_offset;
    logic [N-1:0] r4_second;
    logic [2:0]   r4_sector;

    assign n_xprod = r3_chroma * r3_ramp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_chroma <= r3_chroma;
            r4_offset <= r3_offset;
            r4_second <= n_xprod[2*N-1:N];
            r4_sector <= r3_sector;
        end
    end

    // Stage 5: add offset, route components by sector
    logic [N:0]   n_c_sum;
    logic [N:0]   n_x_sum;
    logic [N-1:0] n_c;
    logic [N-1:0] n_x;
    logic [N-1:0] n_m;
    hsvrgb_pkg::t_rgb_out n_rgb;
    hsvrgb_pkg::t_rgb_out r_out;

    always_comb begin
        n_c_sum = {1'b0, r4_chroma} + {1'b0, r4_offset};
        n_x_sum = {1'b0, r4_second} + {1'b0, r4_offset};
        n_c     = n_c_sum[N-1:0];
        n_x     = n_x_sum[N-1:0];
        n_m     = r4_offset;
        case (r4_sector)
            hsvrgb_pkg::SECT_RY: n_rgb = '{red: n_c, green: n_x, blue: n_m};
            hsvrgb_pkg::SECT_YG: n_rgb = '{red: n_x, green: n_c, blue: n_m};
            hsvrgb_pkg::SECT_GC: n_rgb = '{red: n_m, green: n_c, blue: n_x};
            hsvrgb_pkg::SECT_CB: n_rgb = '{red: n_m, green: n_x, blue: n_c};
            hsvrgb_pkg::SECT_BM: n_rgb = '{red: n_x, green: n_m, blue: n_c};
            default:             n_rgb = '{red: n_c, green: n_m, blue: n_x};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_rgb;
        end
    end

    assign o_data = r_out;

    // Accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    // Stalled output must not lose the word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !w_en |=> r_vld[3] && r_vld[4])
        else $error("stall dropped a word");

    // Half the chroma never exceeds the level, so the HSL offset stays non-negative
    a_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> ({1'b0, r3_chroma[N-1:1]} <= r3_lev))
        else $error("chroma above level");

    // Sector code is always one of the six
    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r4_sector <= hsvrgb_pkg::SECT_MR))
        else $error("hue sector out of range");

endmodule
